// ----- rtl/rie_pkg.sv -----
// Shared types and constants for the RV32I instruction executor.
// No dependencies; imported by every module of the block.
package rie_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EBREAK     = 3'd1,
        ST_EXIT       = 3'd2,
        ST_WRITE      = 3'd3,
        ST_READ       = 3'd4,
        ST_ILLEGAL    = 3'd5,
        ST_MISALIGNED = 3'd6
    } status_t;

    // Major opcodes
    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;
    localparam logic [6:0] OP_FENCE  = 7'h0F;
    localparam logic [6:0] OP_SYSTEM = 7'h73;

    // Fixed system words
    localparam logic [31:0] W_ECALL  = 32'h0000_0073;
    localparam logic [31:0] W_EBREAK = 32'h0010_0073;
    localparam logic [31:0] W_MRET   = 32'h3020_0073;

    // CSR numbers
    localparam logic [11:0] CSRN_MSCRATCH = 12'h340;
    localparam logic [11:0] CSRN_MTVEC    = 12'h305;
    localparam logic [11:0] CSRN_MEPC     = 12'h341;
    localparam logic [11:0] CSRN_MCAUSE   = 12'h342;

    // Host call numbers and trap cause
    localparam logic [31:0] CALL_EXIT  = 32'd93;
    localparam logic [31:0] CALL_WRITE = 32'd64;
    localparam logic [31:0] CALL_READ  = 32'd63;
    localparam logic [31:0] CAUSE_ECALL = 32'd11;

    typedef enum logic [1:0] {
        CSR_SCRATCH,
        CSR_TVEC,
        CSR_EPC,
        CSR_CAUSE
    } csr_sel_t;

    // Architectural state seen by the execute logic
    typedef struct packed {
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] x10;
        logic [31:0] x11;
        logic [31:0] x12;
        logic [31:0] x17;
        logic [31:0] mem_word;
        logic [31:0] mscratch;
        logic [31:0] mtvec;
        logic [31:0] mepc;
        logic [31:0] mcause;
    } ex_in_t;

    // Updates and result produced by the execute logic
    typedef struct packed {
        logic [31:0] next_pc;
        status_t     status;
        logic        wb_valid;
        logic [4:0]  wb_index;
        logic [31:0] wb_value;
        logic [31:0] host_arg0;
        logic [31:0] host_arg1;
        logic [31:0] host_arg2;
        logic        mem_we;
        logic [31:0] mem_addr;
        logic [31:0] mem_wdata;
        logic        csr_we;
        csr_sel_t    csr_sel;
        logic [31:0] csr_wdata;
        logic        trap;
    } ex_out_t;

endpackage

// ----- rtl/rie_dmem.sv -----
// Word-wide data memory with one read and one write port.
// Clears itself after reset, one word per cycle. Uses rie_pkg.
module rie_dmem
    import rie_pkg::*;
#(
    parameter int MEM_WORDS = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         rd_en,
    input  logic [$clog2(MEM_WORDS)-1:0] rd_idx,
    output logic [31:0]                  rd_data,
    input  logic                         wr_en,
    input  logic [$clog2(MEM_WORDS)-1:0] wr_idx,
    input  logic [31:0]                  wr_data,
    output logic                         busy
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]   mem [MEM_WORDS];
    logic [31:0]   rd_data_reg;
    logic [AW-1:0] clr_idx_reg;
    logic          clr_busy_reg;

    // Sweep the array after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else if (clr_busy_reg) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == AW'(MEM_WORDS - 1)) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write port, shared with the clearing sweep
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_idx_reg] <= '0;
        end else if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_busy_reg;
endmodule

// ----- rtl/rie_exec.sv -----
// Decode and execute of one RV32I instruction word.
// Pure combinational logic; uses the types in rie_pkg.
module rie_exec
    import rie_pkg::*;
(
    input  logic [31:0] instr,
    input  ex_in_t      st,
    output ex_out_t     res
);
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [4:0]  rd, r1, r2;
    logic [31:0] immi, imms, immb, immj, immu;
    logic [31:0] a, b, pc, pc4;
    logic [31:0] addr_l, addr_s;
    logic [31:0] lane_b, lane_h;
    logic [31:0] smask, sdata;
    logic [11:0] csrn;
    logic        csr_known;
    logic [31:0] csr_old;
    csr_sel_t    csr_sel;
    logic        take;
    logic        lt_s_ab, lt_u_ab, lt_s_ai, lt_u_ai;
    ex_out_t     r;

    always_comb begin
        op   = instr[6:0];
        f3   = instr[14:12];
        f7   = instr[31:25];
        rd   = instr[11:7];
        r1   = instr[19:15];
        r2   = instr[24:20];
        immi = {{20{instr[31]}}, instr[31:20]};
        imms = {{20{instr[31]}}, instr[31:25], instr[11:7]};
        immb = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
        immj = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
        immu = {instr[31:12], 12'b0};
        a    = st.a;
        b    = st.b;
        pc   = st.pc;
        pc4  = st.pc + 32'd4;
        addr_l = a + immi;
        addr_s = a + imms;
        lt_s_ab = $signed(a) < $signed(b);
        lt_u_ab = a < b;
        lt_s_ai = $signed(a) < $signed(immi);
        lt_u_ai = a < immi;
        lane_b  = st.mem_word >> {addr_l[1:0], 3'b000};
        lane_h  = st.mem_word >> {addr_l[1], 4'b0000};
        csrn    = instr[31:20];

        // Look up the addressed CSR
        csr_known = 1'b1;
        csr_sel   = CSR_CAUSE;
        csr_old   = st.mcause;
        case (csrn)
            CSRN_MSCRATCH: begin csr_sel = CSR_SCRATCH; csr_old = st.mscratch; end
            CSRN_MTVEC:    begin csr_sel = CSR_TVEC;    csr_old = st.mtvec;    end
            CSRN_MEPC:     begin csr_sel = CSR_EPC;     csr_old = st.mepc;     end
            CSRN_MCAUSE:   begin csr_sel = CSR_CAUSE;   csr_old = st.mcause;   end
            default: begin
                csr_known = 1'b0;
                csr_old   = '0;
            end
        endcase

        // Store lane mask and data
        case (f3[1:0])
            2'd0: begin
                smask = 32'h0000_00FF << {addr_s[1:0], 3'b000};
                sdata = {4{b[7:0]}};
            end
            2'd1: begin
                smask = 32'h0000_FFFF << {addr_s[1], 4'b0000};
                sdata = {2{b[15:0]}};
            end
            default: begin
                smask = 32'hFFFF_FFFF;
                sdata = b;
            end
        endcase

        // Branch condition
        case (f3)
            3'd0:    take = a == b;
            3'd1:    take = a != b;
            3'd4:    take = lt_s_ab;
            3'd5:    take = !lt_s_ab;
            3'd6:    take = lt_u_ab;
            3'd7:    take = !lt_u_ab;
            default: take = 1'b0;
        endcase

        r           = '0;
        r.next_pc   = pc4;
        r.status    = ST_OK;
        r.wb_index  = rd;
        r.mem_addr  = addr_s;
        r.mem_wdata = (st.mem_word & ~smask) | (sdata & smask);
        r.csr_sel   = csr_sel;

        case (op)
            OP_LUI: begin
                r.wb_valid = 1'b1;
                r.wb_value = immu;
            end
            OP_AUIPC: begin
                r.wb_valid = 1'b1;
                r.wb_value = pc + immu;
            end
            OP_JAL: begin
                r.wb_valid = 1'b1;
                r.wb_value = pc4;
                r.next_pc  = pc + immj;
            end
            OP_JALR: begin
                if (f3 != 3'd0) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    r.wb_valid = 1'b1;
                    r.wb_value = pc4;
                    r.next_pc  = addr_l & ~32'd1;
                end
            end
            OP_BRANCH: begin
                if (f3 == 3'd2 || f3 == 3'd3) begin
                    r.status = ST_ILLEGAL;
                end else if (take) begin
                    r.next_pc = pc + immb;
                end
            end
            OP_LOAD: begin
                if (f3 == 3'd3 || f3 > 3'd5) begin
                    r.status = ST_ILLEGAL;
                end else if ((f3[1:0] == 2'd1 && addr_l[0]) ||
                             (f3 == 3'd2 && addr_l[1:0] != 2'd0)) begin
                    r.status = ST_MISALIGNED;
                end else begin
                    r.wb_valid = 1'b1;
                    case (f3)
                        3'd0:    r.wb_value = {{24{lane_b[7]}}, lane_b[7:0]};
                        3'd1:    r.wb_value = {{16{lane_h[15]}}, lane_h[15:0]};
                        3'd4:    r.wb_value = {24'b0, lane_b[7:0]};
                        3'd5:    r.wb_value = {16'b0, lane_h[15:0]};
                        default: r.wb_value = st.mem_word;
                    endcase
                end
            end
            OP_STORE: begin
                if (f3 > 3'd2) begin
                    r.status = ST_ILLEGAL;
                end else if ((f3 == 3'd1 && addr_s[0]) ||
                             (f3 == 3'd2 && addr_s[1:0] != 2'd0)) begin
                    r.status = ST_MISALIGNED;
                end else begin
                    r.mem_we = 1'b1;
                end
            end
            OP_IMM: begin
                r.wb_valid = 1'b1;
                case (f3)
                    3'd0: r.wb_value = addr_l;
                    3'd2: r.wb_value = {31'b0, lt_s_ai};
                    3'd3: r.wb_value = {31'b0, lt_u_ai};
                    3'd4: r.wb_value = a ^ immi;
                    3'd6: r.wb_value = a | immi;
                    3'd7: r.wb_value = a & immi;
                    3'd1: begin
                        if (f7 != 7'd0) r.status = ST_ILLEGAL;
                        else r.wb_value = a << r2;
                    end
                    default: begin
                        if (f7 == 7'h00) r.wb_value = a >> r2;
                        else if (f7 == 7'h20) r.wb_value = $unsigned($signed(a) >>> r2);
                        else r.status = ST_ILLEGAL;
                    end
                endcase
            end
            OP_REG: begin
                r.wb_valid = 1'b1;
                if (f7 == 7'h20 && f3 == 3'd0) begin
                    r.wb_value = a - b;
                end else if (f7 == 7'h20 && f3 == 3'd5) begin
                    r.wb_value = $unsigned($signed(a) >>> b[4:0]);
                end else if (f7 != 7'd0) begin
                    r.status = ST_ILLEGAL;
                end else begin
                    case (f3)
                        3'd0:    r.wb_value = a + b;
                        3'd1:    r.wb_value = a << b[4:0];
                        3'd2:    r.wb_value = {31'b0, lt_s_ab};
                        3'd3:    r.wb_value = {31'b0, lt_u_ab};
                        3'd4:    r.wb_value = a ^ b;
                        3'd5:    r.wb_value = a >> b[4:0];
                        3'd6:    r.wb_value = a | b;
                        default: r.wb_value = a & b;
                    endcase
                end
            end
            OP_FENCE: begin
                if (f3 != 3'd0) r.status = ST_ILLEGAL;
            end
            OP_SYSTEM: begin
                if (instr == W_ECALL) begin
                    if (st.x17 == CALL_EXIT || st.x17 == CALL_WRITE ||
                        st.x17 == CALL_READ) begin
                        r.host_arg0 = st.x10;
                        r.host_arg1 = st.x11;
                        r.host_arg2 = st.x12;
                        if (st.x17 == CALL_EXIT) begin
                            r.status = ST_EXIT;
                        end else if (st.x17 == CALL_READ) begin
                            r.status = ST_READ;
                        end else begin
                            r.status   = ST_WRITE;
                            r.wb_valid = 1'b1;
                            r.wb_index = 5'd10;
                            r.wb_value = st.x12;
                        end
                    end else begin
                        r.trap    = 1'b1;
                        r.next_pc = st.mtvec & ~32'd3;
                    end
                end else if (instr == W_EBREAK) begin
                    r.status = ST_EBREAK;
                end else if (instr == W_MRET) begin
                    r.next_pc = st.mepc;
                end else if (f3 == 3'd1 || f3 == 3'd2) begin
                    r.wb_valid  = 1'b1;
                    r.wb_value  = csr_old;
                    r.csr_we    = csr_known && (f3 == 3'd1 || r1 != 5'd0);
                    r.csr_wdata = (f3 == 3'd1) ? a : (csr_old | a);
                end else begin
                    r.status = ST_ILLEGAL;
                end
            end
            default: r.status = ST_ILLEGAL;
        endcase

        // Drop all effects on an error; drop writes to x0
        if (r.status == ST_ILLEGAL || r.status == ST_MISALIGNED) begin
            r.next_pc  = pc;
            r.wb_valid = 1'b0;
            r.mem_we   = 1'b0;
            r.csr_we   = 1'b0;
        end
        if (!r.wb_valid || r.wb_index == 5'd0) begin
            r.wb_valid = 1'b0;
            r.wb_index = '0;
            r.wb_value = '0;
        end
        res = r;
    end
endmodule

// ----- rtl/rv32i_instruction_executor.sv -----
// Top level of the RV32I instruction executor: operand fetch, state, result register.
// Uses rie_pkg, rie_dmem and rie_exec.
//
//  channel  | direction | payload
//  ---------+-----------+-----------------------------------------------------------
//  s_       | in        | instr_word
//  m_       | out       | next_pc, status, wb_valid, wb_index, wb_value, host_arg0..2
//  cfg_     | in        | start_pc (write only)
//
// One instruction per cycle while the result register is not stalled: registers
// and memory are read at acceptance (with bypass from the instruction executing
// that cycle), then executed from the operand registers and written to the
// result register. After reset the data memory is cleared while s_tready stays low.
// A stalled result register holds the execute stage, and so the input.
module rv32i_instruction_executor
    import rie_pkg::*;
#(
    parameter int MEM_WORDS = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [31:0]  cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // [31:0] instr_word
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata    // [31:0] next_pc, [34:32] status, [35] wb_valid,
                                    // [40:36] wb_index, [72:41] wb_value,
                                    // [104:73] host_arg0, [136:105] host_arg1,
                                    // [168:137] host_arg2, rest zero
);
    localparam int AW = $clog2(MEM_WORDS);

    logic [31:0]  rf_reg [32];
    logic [31:0]  pc_reg, mscratch_reg, mtvec_reg, mepc_reg, mcause_reg;
    logic         e_valid_reg;
    logic [31:0]  e_instr_reg, e_a_reg, e_b_reg;
    logic [31:0]  e_x10_reg, e_x11_reg, e_x12_reg, e_x17_reg;
    logic         fwd_hit_reg;
    logic [31:0]  fwd_word_reg;
    logic         out_valid_reg;
    logic [175:0] out_data_reg;

    logic         mem_busy;
    logic [31:0]  mem_rd_data;
    logic         ex_fire, accept;
    ex_in_t       ex_in;
    ex_out_t      ex_out;
    logic [31:0]  a_fwd, b_fwd, x10_fwd, x11_fwd, x12_fwd, x17_fwd;
    logic [31:0]  s_addr;
    logic [AW-1:0] s_idx, w_idx;

    // Handshake
    assign ex_fire  = e_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !mem_busy && (!e_valid_reg || ex_fire);
    assign accept   = s_tvalid && s_tready;

    // Register read with bypass from the executing instruction
    function automatic logic [31:0] rf_fwd(input logic [4:0] idx, input logic fire,
                                           input ex_out_t eo, input logic [31:0] raw);
        if (fire && eo.wb_valid && eo.wb_index == idx) return eo.wb_value;
        return raw;
    endfunction

    always_comb begin
        a_fwd   = rf_fwd(s_tdata[19:15], ex_fire, ex_out, rf_reg[s_tdata[19:15]]);
        b_fwd   = rf_fwd(s_tdata[24:20], ex_fire, ex_out, rf_reg[s_tdata[24:20]]);
        x10_fwd = rf_fwd(5'd10, ex_fire, ex_out, rf_reg[10]);
        x11_fwd = rf_fwd(5'd11, ex_fire, ex_out, rf_reg[11]);
        x12_fwd = rf_fwd(5'd12, ex_fire, ex_out, rf_reg[12]);
        x17_fwd = rf_fwd(5'd17, ex_fire, ex_out, rf_reg[17]);
        // Memory address for a load or store, decided from the raw opcode
        if (s_tdata[6:0] == OP_STORE) begin
            s_addr = a_fwd + {{20{s_tdata[31]}}, s_tdata[31:25], s_tdata[11:7]};
        end else begin
            s_addr = a_fwd + {{20{s_tdata[31]}}, s_tdata[31:20]};
        end
        s_idx = s_addr[AW+1:2];
        w_idx = ex_out.mem_addr[AW+1:2];
    end

    rie_dmem #(.MEM_WORDS(MEM_WORDS)) u_dmem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_idx  (s_idx),
        .rd_data (mem_rd_data),
        .wr_en   (ex_fire && ex_out.mem_we),
        .wr_idx  (w_idx),
        .wr_data (ex_out.mem_wdata),
        .busy    (mem_busy)
    );

    // Execute stage inputs
    always_comb begin
        ex_in.pc       = pc_reg;
        ex_in.a        = e_a_reg;
        ex_in.b        = e_b_reg;
        ex_in.x10      = e_x10_reg;
        ex_in.x11      = e_x11_reg;
        ex_in.x12      = e_x12_reg;
        ex_in.x17      = e_x17_reg;
        ex_in.mem_word = fwd_hit_reg ? fwd_word_reg : mem_rd_data;
        ex_in.mscratch = mscratch_reg;
        ex_in.mtvec    = mtvec_reg;
        ex_in.mepc     = mepc_reg;
        ex_in.mcause   = mcause_reg;
    end

    rie_exec u_exec (
        .instr (e_instr_reg),
        .st    (ex_in),
        .res   (ex_out)
    );

    // Capture the accepted transaction with its operands
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (accept) begin
            e_valid_reg <= 1'b1;
        end else if (ex_fire) begin
            e_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            e_instr_reg  <= s_tdata;
            e_a_reg      <= a_fwd;
            e_b_reg      <= b_fwd;
            e_x10_reg    <= x10_fwd;
            e_x11_reg    <= x11_fwd;
            e_x12_reg    <= x12_fwd;
            e_x17_reg    <= x17_fwd;
            fwd_hit_reg  <= ex_fire && ex_out.mem_we && (w_idx == s_idx);
            fwd_word_reg <= ex_out.mem_wdata;
        end
    end

    // Architectural state update
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf_reg[i] <= '0;
            pc_reg       <= '0;
            mscratch_reg <= '0;
            mtvec_reg    <= '0;
            mepc_reg     <= '0;
            mcause_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                pc_reg <= cfg_wr_data;
            end else if (ex_fire) begin
                pc_reg <= ex_out.next_pc;
            end
            if (ex_fire) begin
                if (ex_out.wb_valid) rf_reg[ex_out.wb_index] <= ex_out.wb_value;
                if (ex_out.trap) begin
                    mepc_reg   <= pc_reg;
                    mcause_reg <= CAUSE_ECALL;
                end
                if (ex_out.csr_we) begin
                    case (ex_out.csr_sel)
                        CSR_SCRATCH: mscratch_reg <= ex_out.csr_wdata;
                        CSR_TVEC:    mtvec_reg    <= ex_out.csr_wdata;
                        CSR_EPC:     mepc_reg     <= ex_out.csr_wdata;
                        default:     mcause_reg   <= ex_out.csr_wdata;
                    endcase
                end
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ex_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ex_fire) begin
            out_data_reg <= {7'b0, ex_out.host_arg2, ex_out.host_arg1, ex_out.host_arg0,
                             ex_out.wb_value, ex_out.wb_index, ex_out.wb_valid,
                             ex_out.status, ex_out.next_pc};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

// ----- sim/tb_top.sv -----
// Self-checking bench for rv32i_instruction_executor: random instruction streams vs a local ISS.
// Depends on rie_pkg and the executor RTL; no files or arguments are read.
`timescale 1ns / 100ps

module tb_top;
    import rie_pkg::*;

    localparam int MEM_WORDS = 1024;
    localparam int WD_LIMIT  = 20000;

    // Retire record, listed from the highest bits of m_tdata down
    typedef struct packed {
        logic [31:0] host_arg2;
        logic [31:0] host_arg1;
        logic [31:0] host_arg0;
        logic [31:0] wb_value;
        logic [4:0]  wb_index;
        logic        wb_valid;
        status_t     status;
        logic [31:0] next_pc;
    } retire_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [31:0]  cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [31:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;

    rv32i_instruction_executor #(.MEM_WORDS(MEM_WORDS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #4 aclk = ~aclk;

    // Shadow architectural state
    logic [31:0] gpr [32];
    logic [31:0] mem [MEM_WORDS];
    logic [31:0] pc_q, mscratch_q, mtvec_q, mepc_q, mcause_q;

    logic [31:0] instr_q [$];
    retire_t     retire_q [$];
    int          mismatches = 0;
    int          retired = 0;
    int          idle_cycles = 0;
    bit          drv_en = 1'b0;
    int          burst_left = 0, gap_left = 0;
    int          n_ecall = 0, n_trap = 0;

    function automatic logic [31:0] sext(input logic [31:0] v, input int bits);
        logic [31:0] m;
        m = 32'hFFFF_FFFF << bits;
        return v[bits-1] ? (v | m) : (v & ~m);
    endfunction

    function automatic logic [7:0] get_byte(input logic [31:0] a);
        a = a % (MEM_WORDS * 4);
        return mem[a >> 2][(a & 3) * 8 +: 8];
    endfunction

    function automatic void put_byte(input logic [31:0] a, input logic [7:0] v);
        a = a % (MEM_WORDS * 4);
        mem[a >> 2][(a & 3) * 8 +: 8] = v;
    endfunction

    // Execute one instruction on the shadow state and return its retire record
    function automatic retire_t execute_instr(input logic [31:0] w);
        retire_t     r;
        logic [6:0]  op;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [4:0]  rd, r1, r2;
        logic [31:0] a, b, immi, val, addr, t, nxt, old, nr;
        logic [11:0] csrn;
        logic        wr, take, known;
        status_t     st;
        op = w[6:0]; f3 = w[14:12]; f7 = w[31:25];
        rd = w[11:7]; r1 = w[19:15]; r2 = w[24:20];
        a = gpr[r1]; b = gpr[r2];
        immi = sext({20'd0, w[31:20]}, 12);
        nxt = pc_q + 4; st = ST_OK; wr = 1'b0; val = '0; r = '0;
        case (op)
            OP_LUI: begin wr = 1; val = {w[31:12], 12'd0}; end
            OP_AUIPC: begin wr = 1; val = pc_q + {w[31:12], 12'd0}; end
            OP_JAL: begin
                wr = 1; val = pc_q + 4;
                t = {11'd0, w[31], w[19:12], w[20], w[30:21], 1'b0};
                nxt = pc_q + sext(t, 21);
            end
            OP_JALR: begin
                if (f3 != 0) st = ST_ILLEGAL;
                else begin wr = 1; val = pc_q + 4; nxt = (a + immi) & ~32'd1; end
            end
            OP_BRANCH: begin
                t = {19'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
                take = 0;
                case (f3)
                    3'd0: take = a == b;
                    3'd1: take = a != b;
                    3'd4: take = $signed(a) < $signed(b);
                    3'd5: take = !($signed(a) < $signed(b));
                    3'd6: take = a < b;
                    3'd7: take = a >= b;
                    default: st = ST_ILLEGAL;
                endcase
                if (take) nxt = pc_q + sext(t, 13);
            end
            OP_LOAD: begin
                addr = a + immi;
                if (f3 == 3 || f3 > 5) st = ST_ILLEGAL;
                else if ((f3[1:0] == 1 && addr[0]) || (f3 == 2 && addr[1:0] != 0))
                    st = ST_MISALIGNED;
                else begin
                    wr = 1;
                    if (f3[1:0] == 0) val = {24'd0, get_byte(addr)};
                    else if (f3[1:0] == 1) val = {16'd0, get_byte(addr + 1), get_byte(addr)};
                    else val = {get_byte(addr + 3), get_byte(addr + 2),
                                get_byte(addr + 1), get_byte(addr)};
                    if (f3 == 0) val = sext(val, 8);
                    else if (f3 == 1) val = sext(val, 16);
                end
            end
            OP_STORE: begin
                addr = a + sext({20'd0, f7, rd}, 12);
                if (f3 > 2) st = ST_ILLEGAL;
                else if ((f3 == 1 && addr[0]) || (f3 == 2 && addr[1:0] != 0))
                    st = ST_MISALIGNED;
                else for (int i = 0; i < (1 << f3); i++) put_byte(addr + i, b[8*i +: 8]);
            end
            OP_IMM: begin
                wr = 1;
                case (f3)
                    3'd0: val = a + immi;
                    3'd2: val = ($signed(a) < $signed(immi)) ? 1 : 0;
                    3'd3: val = (a < immi) ? 1 : 0;
                    3'd4: val = a ^ immi;
                    3'd6: val = a | immi;
                    3'd7: val = a & immi;
                    3'd1: if (f7 != 0) st = ST_ILLEGAL; else val = a << r2;
                    default: begin
                        if (f7 == 0) val = a >> r2;
                        else if (f7 == 7'h20) val = $signed(a) >>> r2;
                        else st = ST_ILLEGAL;
                    end
                endcase
            end
            OP_REG: begin
                wr = 1;
                if (f7 == 7'h20 && f3 == 0) val = a - b;
                else if (f7 == 7'h20 && f3 == 5) val = $signed(a) >>> b[4:0];
                else if (f7 != 0) st = ST_ILLEGAL;
                else case (f3)
                    3'd0: val = a + b;
                    3'd1: val = a << b[4:0];
                    3'd2: val = ($signed(a) < $signed(b)) ? 1 : 0;
                    3'd3: val = (a < b) ? 1 : 0;
                    3'd4: val = a ^ b;
                    3'd5: val = a >> b[4:0];
                    3'd6: val = a | b;
                    default: val = a & b;
                endcase
            end
            OP_FENCE: if (f3 != 0) st = ST_ILLEGAL;
            OP_SYSTEM: begin
                if (w == W_ECALL) begin
                    nr = gpr[17];
                    n_ecall++;
                    if (nr == CALL_EXIT || nr == CALL_WRITE || nr == CALL_READ) begin
                        r.host_arg0 = gpr[10]; r.host_arg1 = gpr[11]; r.host_arg2 = gpr[12];
                        if (nr == CALL_EXIT) st = ST_EXIT;
                        else if (nr == CALL_READ) st = ST_READ;
                        else begin st = ST_WRITE; wr = 1; rd = 5'd10; val = gpr[12]; end
                    end else begin
                        n_trap++;
                        mepc_q = pc_q; mcause_q = CAUSE_ECALL;
                        nxt = mtvec_q & ~32'd3;
                    end
                end else if (w == W_EBREAK) st = ST_EBREAK;
                else if (w == W_MRET) nxt = mepc_q;
                else if (f3 == 1 || f3 == 2) begin
                    csrn = w[31:20];
                    known = 1; old = '0;
                    case (csrn)
                        CSRN_MSCRATCH: old = mscratch_q;
                        CSRN_MTVEC:    old = mtvec_q;
                        CSRN_MEPC:     old = mepc_q;
                        CSRN_MCAUSE:   old = mcause_q;
                        default:       known = 0;
                    endcase
                    if (known && (f3 == 1 || r1 != 0)) begin
                        t = (f3 == 1) ? a : (old | a);
                        case (csrn)
                            CSRN_MSCRATCH: mscratch_q = t;
                            CSRN_MTVEC:    mtvec_q = t;
                            CSRN_MEPC:     mepc_q = t;
                            default:       mcause_q = t;
                        endcase
                    end
                    wr = 1; val = old;
                end else st = ST_ILLEGAL;
            end
            default: st = ST_ILLEGAL;
        endcase
        if (st == ST_ILLEGAL || st == ST_MISALIGNED) begin
            nxt = pc_q; wr = 0;
            r.host_arg0 = '0; r.host_arg1 = '0; r.host_arg2 = '0;
        end
        if (wr && rd != 0) begin
            gpr[rd] = val;
            r.wb_valid = 1; r.wb_index = rd; r.wb_value = val;
        end
        gpr[0] = '0;
        pc_q = nxt;
        r.next_pc = nxt; r.status = st;
        return r;
    endfunction

    // Random register, biased toward a0..a2/a7 and a few base registers
    function automatic logic [4:0] pick_reg();
        case ($urandom_range(0, 3))
            0: return 5'($urandom_range(0, 31));
            1: return 5'($urandom_range(10, 12));
            2: return 5'd17;
            default: return 5'($urandom_range(1, 5));
        endcase
    endfunction

    function automatic logic [31:0] gen_instr();
        logic [31:0] w;
        logic [11:0] csrs [5];
        logic [4:0]  rd, r1, r2;
        logic [2:0]  f3;
        int          k;
        csrs = '{CSRN_MSCRATCH, CSRN_MTVEC, CSRN_MEPC, CSRN_MCAUSE, 12'h7C0};
        rd = pick_reg(); r1 = pick_reg(); r2 = pick_reg();
        f3 = 3'($urandom_range(0, 7));
        w = $urandom;
        k = $urandom_range(0, 99);
        if (k < 5) return w;                                   // noise
        if (k < 15) return {w[31:12], rd, OP_LUI};
        if (k < 18) return {w[31:12], rd, OP_AUIPC};
        if (k < 21) return {w[31:12], rd, OP_JAL};
        if (k < 23) return {w[31:20], r1, 3'($urandom_range(0, 8) == 0), rd, OP_JALR};
        if (k < 30) return {w[31:25], r2, r1, f3, w[11:7], OP_BRANCH};
        // loads/stores: small offsets off a register, mostly aligned
        if (k < 42) return {w[31:29] == 0 ? w[31:20] : {w[31:22], 2'b00}, r1,
                            ($urandom_range(0, 9) == 0) ? f3 : 3'($urandom_range(0, 5)),
                            rd, OP_LOAD};
        if (k < 54) return {w[31:25], r2, r1,
                            ($urandom_range(0, 9) == 0) ? f3 : 3'($urandom_range(0, 2)),
                            w[29] ? {w[11:9], 2'b00} : w[11:7], OP_STORE};
        if (k < 70) begin
            if (f3 == 1 || f3 == 5)
                return {1'b0, ($urandom_range(0, 9) == 0) ? 1'b1 : (f3 == 5 && w[30]),
                        ($urandom_range(0, 15) == 0) ? w[29:25] : 5'd0, w[24:20], r1, f3,
                        rd, OP_IMM};
            return {w[31:20], r1, f3, rd, OP_IMM};
        end
        if (k < 84) return {($urandom_range(0, 15) == 0) ? w[31:25] :
                            ((f3 == 0 || f3 == 5) && w[30] ? 7'h20 : 7'h00),
                            r2, r1, f3, rd, OP_REG};
        if (k < 86) return {w[31:15], ($urandom_range(0, 3) == 0) ? 3'd1 : 3'd0, w[11:7],
                            OP_FENCE};
        if (k < 91) return W_ECALL;
        if (k < 92) return W_EBREAK;
        if (k < 94) return W_MRET;
        // CSR ops, mostly RW/RS, sometimes other funct3
        return {csrs[$urandom_range(0, 4)], r1,
                ($urandom_range(0, 7) == 0) ? f3 : 3'($urandom_range(1, 2)), rd, OP_SYSTEM};
    endfunction

    // Sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s_tvalid <= 1'b0;
        end
        if (drv_en && (!s_tvalid || s_tready) && instr_q.size() > 0) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= instr_q.pop_front();
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // Receiver stall pattern: alternating ready and stall windows
    int stall_ctr = 0;
    always @(posedge aclk) begin
        if (stall_ctr == 0) begin
            m_tready <= ~m_tready;
            stall_ctr <= m_tready ? $urandom_range(0, 4) : $urandom_range(1, 30);
        end else begin
            stall_ctr <= stall_ctr - 1;
        end
    end

    // Monitor: compare each retired transaction with the oldest prediction
    always @(posedge aclk) begin
        retire_t got, exp_r;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (m_tvalid && m_tready) begin
            got = m_tdata[168:0];
            retired <= retired + 1;
            if (retire_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected retire %h", got);
            end else begin
                exp_r = retire_q.pop_front();
                if (got !== exp_r) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("retire mismatch: exp pc=%h st=%0d wb=%b/%0d/%h h=%h/%h/%h\n%s",
                                 exp_r.next_pc, exp_r.status, exp_r.wb_valid, exp_r.wb_index,
                                 exp_r.wb_value, exp_r.host_arg0, exp_r.host_arg1,
                                 exp_r.host_arg2,
                                 $sformatf("   got pc=%h st=%0d wb=%b/%0d/%h h=%h/%h/%h",
                                 got.next_pc, got.status, got.wb_valid, got.wb_index,
                                 got.wb_value, got.host_arg0, got.host_arg1, got.host_arg2));
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (aresetn && idle_cycles > WD_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Queue one instruction, predicting its retire record at once
    task automatic push_instr(input logic [31:0] w);
        instr_q.push_back(w);
        retire_q.push_back(execute_instr(w));
    endtask

    // Let the pipe drain before touching start_pc
    task automatic drain();
        drv_en = 1'b1;
        while (instr_q.size() > 0 || s_tvalid || retire_q.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        drv_en = 1'b0;
    endtask

    task automatic write_start_pc(input logic [31:0] v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pc_q = v;
    endtask

    initial begin
        logic [31:0] pcs [4];
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        for (int i = 0; i < MEM_WORDS; i++) mem[i] = '0;
        pc_q = '0; mscratch_q = '0; mtvec_q = '0; mepc_q = '0; mcause_q = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes, several classes, host calls, trap, misaligned, wrap
        push_instr({20'hFFFFF, 5'd1, OP_LUI});
        push_instr({12'hFFF, 5'd1, 3'd0, 5'd2, OP_IMM});            // x2 = x1 - 1
        push_instr({20'h80000, 5'd3, OP_AUIPC});
        push_instr({7'h20, 5'd4, 5'd2, 3'd5, 5'd4, OP_IMM});        // srai 4
        push_instr({7'h00, 5'd2, 5'd1, 3'd2, 5'd5, OP_REG});        // slt
        push_instr({7'h00, 5'd2, 5'd2, 3'd2, 5'd0, OP_STORE});      // sw x2, 0(x2)
        push_instr({12'd1, 5'd0, 3'd1, 5'd6, OP_LOAD});             // lh misaligned
        push_instr({12'd4092, 5'd0, 3'd4, 5'd6, OP_LOAD});          // lbu near top
        push_instr({12'd4, 5'd1, 3'd2, 5'd7, OP_LOAD});             // lw wraps
        push_instr({12'd93, 5'd0, 3'd0, 5'd17, OP_IMM});
        push_instr(W_ECALL);
        push_instr({12'd64, 5'd0, 3'd0, 5'd17, OP_IMM});
        push_instr({12'h7FF, 5'd0, 3'd0, 5'd12, OP_IMM});
        push_instr(W_ECALL);
        push_instr({12'd63, 5'd0, 3'd0, 5'd17, OP_IMM});
        push_instr(W_ECALL);
        push_instr({12'h103, 5'd0, 3'd0, 5'd8, OP_IMM});
        push_instr({CSRN_MTVEC, 5'd8, 3'd1, 5'd9, OP_SYSTEM});
        push_instr({12'd1, 5'd0, 3'd0, 5'd17, OP_IMM});
        push_instr(W_ECALL);                                        // traps
        push_instr({CSRN_MCAUSE, 5'd0, 3'd2, 5'd9, OP_SYSTEM});
        push_instr(W_MRET);
        push_instr(W_EBREAK);
        push_instr({12'hFFF, 5'd1, 3'd3, 5'd9, OP_SYSTEM});         // csrrc illegal
        push_instr(32'hFFFF_FFFF);
        drain();

        // Random phases across several start_pc settings
        pcs = '{32'hFFFF_FFFC, 32'h0000_0000, $urandom, 32'h8000_0000};
        for (int p = 0; p < 4; p++) begin
            write_start_pc(pcs[p]);
            for (int i = 0; i < 330; i++) push_instr(gen_instr());
            drain();
        end
        repeat (10) @(posedge aclk);

        $display("covered %0d retires over 5 start_pc settings, %0d ecalls (%0d traps)",
                 retired, n_ecall, n_trap);
        if (mismatches == 0 && retire_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches, %0d predictions left", mismatches, retire_q.size());
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
